/* rtl/enhanced_clock_frame_allocator_unit_defines.svh */
`ifndef ENHANCED_CLOCK_FRAME_ALLOCATOR_UNIT_DEFINES_SVH
`define ENHANCED_CLOCK_FRAME_ALLOCATOR_UNIT_DEFINES_SVH

// same-cycle implication, checked on aclk outside reset
`define ECFA_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked on aclk outside reset
`define ECFA_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/ecfa_pkg.sv */
`timescale 1ns / 1ps

package ecfa_pkg;

    localparam int FRAMES_DEF = 64;
    localparam int CFG_W      = 7;
    localparam int CFG_RESET  = 64;
    localparam int MODE_W     = 2;
    localparam int IDX_W      = 6;
    localparam int S_DATA_W   = 8;
    localparam int M_DATA_W   = 8;

    localparam logic [MODE_W-1:0] MODE_ACCESS = 2'd0;
    localparam logic [MODE_W-1:0] MODE_ALLOC  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_FREE   = 2'd2;

    typedef struct packed {
        logic accept;
        logic want_mod;
        logic grant_free;
        logic grant_victim;
        logic clear_visited;
        logic sweep_use;
    } cmd_t;

    typedef struct packed {
        logic free_found;
        logic victim_found;
        logic out_room;
    } stat_t;

endpackage

/* rtl/ecfa_ctrl.sv */
`timescale 1ns / 1ps

`include "enhanced_clock_frame_allocator_unit_defines.svh"

module ecfa_ctrl (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    input  logic [ecfa_pkg::MODE_W-1:0]   mode,
    input  ecfa_pkg::stat_t               stat,
    output logic                          s_tready,
    output ecfa_pkg::cmd_t                cmd
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_FREE = 3'd1;
    localparam logic [2:0] ST_P1   = 3'd2;
    localparam logic [2:0] ST_P2   = 3'd3;
    localparam logic [2:0] ST_P3   = 3'd4;
    localparam logic [2:0] ST_P4   = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    assign s_tready = (state_reg == ST_IDLE);

    always_comb begin
        state_next        = state_reg;
        cmd               = '0;
        cmd.accept        = s_tvalid && (state_reg == ST_IDLE);
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid && (mode == ecfa_pkg::MODE_ALLOC)) begin
                    state_next = ST_FREE;
                end
            end
            ST_FREE: begin
                if (stat.free_found) begin
                    if (stat.out_room) begin
                        cmd.grant_free = 1'b1;
                        state_next     = ST_IDLE;
                    end
                end else begin
                    state_next = ST_P1;
                end
            end
            ST_P1, ST_P3: begin
                cmd.want_mod = 1'b0;
                if (stat.victim_found) begin
                    if (stat.out_room) begin
                        cmd.grant_victim = 1'b1;
                        state_next       = ST_IDLE;
                    end
                end else begin
                    state_next = (state_reg == ST_P1) ? ST_P2 : ST_P4;
                end
            end
            ST_P2: begin
                cmd.want_mod = 1'b1;
                if (stat.victim_found) begin
                    if (stat.out_room) begin
                        cmd.grant_victim  = 1'b1;
                        cmd.clear_visited = 1'b1;
                        state_next        = ST_IDLE;
                    end
                end else begin
                    cmd.sweep_use = 1'b1;
                    state_next    = ST_P3;
                end
            end
            ST_P4: begin
                cmd.want_mod = 1'b1;
                if (stat.out_room) begin
                    cmd.grant_victim = 1'b1;
                    state_next       = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    `ECFA_ASSERT_NXT(a_alloc_leaves_idle, cmd.accept && (mode == ecfa_pkg::MODE_ALLOC), state_reg == ST_FREE, "allocate did not start search")
    `ECFA_ASSERT_IMP(a_grant_needs_room, cmd.grant_free || cmd.grant_victim, stat.out_room, "grant while result register full")
    `ECFA_ASSERT_IMP(a_sweep_alone, cmd.sweep_use, !cmd.grant_free && !cmd.grant_victim, "sweep together with grant")

endmodule

/* rtl/ecfa_datapath.sv */
`timescale 1ns / 1ps

`include "enhanced_clock_frame_allocator_unit_defines.svh"

module ecfa_datapath #(
    parameter int FRAMES = ecfa_pkg::FRAMES_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_valid,
    input  logic [ecfa_pkg::CFG_W-1:0]      cfg_data,
    input  logic [ecfa_pkg::MODE_W-1:0]     mode,
    input  logic [ecfa_pkg::IDX_W-1:0]      frame_index,
    input  logic                            is_write,
    input  ecfa_pkg::cmd_t                  cmd,
    input  logic                            m_tready,
    output ecfa_pkg::stat_t                 stat,
    output logic                            m_tvalid,
    output logic [ecfa_pkg::M_DATA_W-1:0]   m_tdata
);

    localparam int FW   = $clog2(FRAMES);
    localparam int NW   = $clog2(FRAMES + 1);
    localparam int CMPW = (NW > ecfa_pkg::CFG_W) ? NW : ecfa_pkg::CFG_W;

    function automatic logic [NW-1:0] clamp_n(input logic [ecfa_pkg::CFG_W-1:0] v);
        logic [CMPW-1:0] w;
        w = CMPW'(v);
        if (w == '0) begin
            return NW'(1);
        end else if (w > CMPW'(FRAMES)) begin
            return NW'(FRAMES);
        end else begin
            return NW'(w);
        end
    endfunction

    function automatic logic [FRAMES-1:0] lt_mask(input logic [NW-1:0] a);
        logic [FRAMES-1:0] m;
        for (int i = 0; i < FRAMES; i++) begin
            m[i] = (NW'(i) < a);
        end
        return m;
    endfunction

    function automatic logic [FRAMES-1:0] ge_mask(input logic [FW-1:0] a);
        logic [FRAMES-1:0] m;
        for (int i = 0; i < FRAMES; i++) begin
            m[i] = (FW'(i) >= a);
        end
        return m;
    endfunction

    function automatic logic [FRAMES-1:0] dec(input logic [FW-1:0] a);
        logic [FRAMES-1:0] m;
        for (int i = 0; i < FRAMES; i++) begin
            m[i] = (FW'(i) == a);
        end
        return m;
    endfunction

    function automatic logic [FW-1:0] first_one(input logic [FRAMES-1:0] x);
        logic [FRAMES-1:0] oh;
        logic [FW-1:0]     idx;
        oh  = x & (~x + FRAMES'(1));
        idx = '0;
        for (int i = 0; i < FRAMES; i++) begin
            idx = idx | (oh[i] ? FW'(i) : '0);
        end
        return idx;
    endfunction

    logic [FRAMES-1:0]             occ_reg, occ_next;
    logic [FRAMES-1:0]             use_reg, use_next;
    logic [FRAMES-1:0]             mod_reg, mod_next;
    logic [FW-1:0]                 hand_reg, hand_next;
    logic [FW-1:0]                 start_reg, start_next;
    logic [NW-1:0]                 n_reg, n_next;
    logic                          m_valid_reg, m_valid_next;
    logic [ecfa_pkg::M_DATA_W-1:0] m_data_reg, m_data_next;

    logic [FRAMES-1:0] live;
    logic [FRAMES-1:0] free_cand;
    logic [FW-1:0]     free_idx;
    logic [FRAMES-1:0] cand;
    logic [FRAMES-1:0] cand_hi;
    logic [FW-1:0]     cand_idx;
    logic              cand_found;
    logic [FW-1:0]     victim;
    logic [FRAMES-1:0] victim_oh;
    logic [FRAMES-1:0] visited;
    logic [FRAMES-1:0] in_oh;
    logic              in_range;
    logic [NW-1:0]     hand_inc;
    logic              out_room;

    assign live       = lt_mask(n_reg);
    assign free_cand  = ~occ_reg & live;
    assign free_idx   = first_one(free_cand);
    assign cand       = ~use_reg & (cmd.want_mod ? mod_reg : ~mod_reg) & live;
    assign cand_hi    = cand & ge_mask(start_reg);
    assign cand_found = |cand;
    assign cand_idx   = (|cand_hi) ? first_one(cand_hi) : first_one(cand);
    assign victim     = cand_found ? cand_idx : start_reg;
    assign victim_oh  = dec(victim);
    assign visited    = (victim >= start_reg)
                      ? (ge_mask(start_reg) & lt_mask(NW'(victim)))
                      : ((ge_mask(start_reg) & live) | lt_mask(NW'(victim)));
    assign in_range   = (CMPW'(frame_index) < CMPW'(n_reg));
    assign in_oh      = dec(FW'(frame_index));
    assign hand_inc   = NW'(victim) + NW'(1);
    assign out_room   = !m_valid_reg || m_tready;

    assign stat.free_found   = |free_cand;
    assign stat.victim_found = cand_found;
    assign stat.out_room     = out_room;

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    always_comb begin
        occ_next     = occ_reg;
        use_next     = use_reg;
        mod_next     = mod_reg;
        hand_next    = hand_reg;
        start_next   = start_reg;
        n_next       = cfg_valid ? clamp_n(cfg_data) : n_reg;
        m_valid_next = m_valid_reg && !m_tready;
        m_data_next  = m_data_reg;

        if (cmd.accept) begin
            start_next = (NW'(hand_reg) < n_reg) ? hand_reg : '0;
            if (in_range && (mode == ecfa_pkg::MODE_ACCESS)) begin
                use_next = use_reg | in_oh;
                if (is_write) begin
                    mod_next = mod_reg | in_oh;
                end
            end
            if (in_range && (mode == ecfa_pkg::MODE_FREE)) begin
                occ_next = occ_reg & ~in_oh;
            end
        end

        if (cmd.grant_free) begin
            occ_next     = occ_reg | dec(free_idx);
            m_valid_next = 1'b1;
            m_data_next  = {1'b0, 1'b1, ecfa_pkg::IDX_W'(free_idx)};
        end

        if (cmd.grant_victim) begin
            occ_next     = occ_reg | victim_oh;
            use_next     = (use_reg & ~(cmd.clear_visited ? visited : '0)) | victim_oh;
            mod_next     = mod_reg & ~victim_oh;
            hand_next    = (hand_inc >= n_reg) ? '0 : FW'(hand_inc);
            m_valid_next = 1'b1;
            m_data_next  = {|(mod_reg & victim_oh), 1'b0, ecfa_pkg::IDX_W'(victim)};
        end

        if (cmd.sweep_use) begin
            use_next = use_reg & ~live;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            occ_reg     <= '0;
            use_reg     <= '0;
            mod_reg     <= '0;
            hand_reg    <= '0;
            n_reg       <= clamp_n(ecfa_pkg::CFG_W'(ecfa_pkg::CFG_RESET));
            m_valid_reg <= 1'b0;
        end else begin
            occ_reg     <= occ_next;
            use_reg     <= use_next;
            mod_reg     <= mod_next;
            hand_reg    <= hand_next;
            n_reg       <= n_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        start_reg  <= start_next;
        m_data_reg <= m_data_next;
    end

    `ECFA_ASSERT_IMP(a_free_grant_found, cmd.grant_free, stat.free_found, "free grant with no free frame")
    `ECFA_ASSERT_NXT(a_grant_loads_out, cmd.grant_free || cmd.grant_victim, m_valid_reg, "grant did not load result")
    `ECFA_ASSERT_NXT(a_victim_marked, cmd.grant_victim, |(occ_reg & use_reg & ~mod_reg), "victim bits not updated")

endmodule

/* rtl/enhanced_clock_frame_allocator_unit.sv */
`timescale 1ns / 1ps

// Page-frame allocator with enhanced second-chance clock replacement. Access and
// free transactions are applied as soon as they are accepted. An allocate
// transaction grants a free frame when one exists, otherwise it searches in passes,
// one per controller state P1 to P4, each a rotated priority search over the
// configured frames in the datapath. A finished grant waits in the result register
// while the next access or free transaction is taken; the search stalls only if a
// new grant finds that register still full.

module enhanced_clock_frame_allocator_unit #(
    parameter int FRAMES = ecfa_pkg::FRAMES_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [ecfa_pkg::CFG_W-1:0]      cfg_data,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [ecfa_pkg::S_DATA_W-1:0]   s_tdata,   // frame_index, is_write, zero pad
    input  logic [ecfa_pkg::MODE_W-1:0]     s_tuser,   // mode
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [ecfa_pkg::M_DATA_W-1:0]   m_tdata    // granted_frame, was_free, victim_dirty
);

    ecfa_pkg::cmd_t  cmd;
    ecfa_pkg::stat_t stat;

    assign cfg_ready = 1'b1;

    ecfa_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .mode     (s_tuser),
        .stat     (stat),
        .s_tready (s_tready),
        .cmd      (cmd)
    );

    ecfa_datapath #(
        .FRAMES (FRAMES)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_valid   (cfg_valid),
        .cfg_data    (cfg_data),
        .mode        (s_tuser),
        .frame_index (s_tdata[ecfa_pkg::IDX_W-1:0]),
        .is_write    (s_tdata[ecfa_pkg::IDX_W]),
        .cmd         (cmd),
        .m_tready    (m_tready),
        .stat        (stat),
        .m_tvalid    (m_tvalid),
        .m_tdata     (m_tdata)
    );

endmodule
